[rtl/core/paged_bump_allocator_macros.svh]
// Assertion macros for the paged bump allocator checker.
// Depends on nothing; the including module must provide a clk signal.
`ifndef PAGED_BUMP_ALLOCATOR_MACROS_SVH
`define PAGED_BUMP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define PBA_ASSERT_SAME(label, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("paged_bump_allocator: same-cycle check failed");

// Next-cycle implication, checked only outside reset.
`define PBA_ASSERT_NEXT(label, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("paged_bump_allocator: next-cycle check failed");

`endif

[rtl/core/pba_pkg.sv]
// Shared constants, status codes and interface structs of the paged bump allocator.
// No dependencies; the RTL modules refer to it by scoped names, the testbench modules import it.
package pba_pkg;

  localparam int MAX_PAGES  = 8;
  localparam int PAGE_W     = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W      = $clog2(MAX_PAGES + 1);
  localparam int PAGE_IDX_W = 3;

  localparam int SIZE_W   = 32;
  localparam int ALIGN_W  = 5;
  localparam int FRAME_W  = 64;
  localparam int USED_W   = 36;
  localparam int OFF_W    = SIZE_W + 1;
  localparam int ALU_W    = USED_W + 1;
  localparam int STATUS_W = 2;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 3;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [SIZE_W-1:0] DEFAULT_PAGE_RESET = 32'd65536;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_PAGE   = 2'd3;

  // Request kinds carried on in_tuser.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FRAME = 1'b1;

  // Register index of default_page_bytes, decoded from cfg_paddr[2].
  localparam logic REG_DEFAULT_PAGE = 1'b0;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic [OFF_W-1:0] mask;
    logic             mask_en;
    logic [ALU_W-1:0] c;
  } alu_op_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic [ALU_W-1:0] res;
    logic             gt;
  } alu_res_t;

  typedef struct packed {
    logic              wr_cap;
    logic              wr_fill;
    logic              clr_fill;
    logic [PAGE_W-1:0] wr_addr;
    logic [SIZE_W-1:0] cap;
    logic [SIZE_W-1:0] fill;
  } pt_cmd_t;

endpackage

[rtl/core/paged_bump_allocator.sv]
// One transaction at a time: a new-frame or zero-size request goes from START straight to EMIT;
// an allocation passes ROUND and CHECK, then ACCUM if it fits the active page, or moves on to
// the next page or appends one through NEED and APPEND and rounds again, or fails; EMIT waits for
// a free result register. The shared adder is used at most once per sequencer step. Reset (rst_n, synchronous,
// active low) empties the page table, selects page 0, clears the last frame number and the byte
// count and sets default_page_bytes to 65536. Depends on pba_pkg, pba_alu and pba_page_table.
module paged_bump_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // request_bytes [31:0], align_log2 [36:32], frame_number [100:37], zero pad above.
  input  logic [pba_pkg::IN_TDATA_W-1:0]    in_tdata,
  // req_type [0].
  input  logic                              in_tuser,
  // Result channel.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // page_index [2:0], block_offset [34:3], used_bytes [70:35], zero pad above.
  output logic [pba_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // status [1:0], frame_was_reset [2].
  output logic [pba_pkg::OUT_TUSER_W-1:0]   out_tuser,
  // Configuration port.
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [pba_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [pba_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [pba_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  // The sequencer walks one request through the shared unit. ROUND aligns the
  // page fill up, CHECK adds the size and compares with the page capacity,
  // NEED sizes a page to append, APPEND adds it, ACCUM updates the byte count,
  // and EMIT hands the result to the output register once it is free.
  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_ROUND,
    S_CHECK,
    S_NEED,
    S_APPEND,
    S_ACCUM,
    S_EMIT
  } state_t;

  state_t                              state_r, state_nxt;

  logic                                req_type_r, req_type_nxt;
  logic [pba_pkg::SIZE_W-1:0]          size_r, size_nxt;
  logic [pba_pkg::ALIGN_W-1:0]         alog_r, alog_nxt;
  logic [pba_pkg::FRAME_W-1:0]         frame_r, frame_nxt;

  logic [pba_pkg::SIZE_W-1:0]          default_r, default_nxt;
  logic [pba_pkg::CNT_W-1:0]           total_r, total_nxt;
  logic [pba_pkg::PAGE_W-1:0]          active_r, active_nxt;
  logic [pba_pkg::FRAME_W-1:0]         prev_r, prev_nxt;
  logic [pba_pkg::USED_W-1:0]          granted_r, granted_nxt;

  logic                                pass_r, pass_nxt;
  logic [pba_pkg::OFF_W-1:0]           off_r, off_nxt;
  logic [pba_pkg::OFF_W-1:0]           need_r, need_nxt;
  logic                                need_gt_r, need_gt_nxt;

  logic [pba_pkg::STATUS_W-1:0]        res_status_r, res_status_nxt;
  logic [pba_pkg::PAGE_W-1:0]          res_page_r, res_page_nxt;
  logic [pba_pkg::SIZE_W-1:0]          res_off_r, res_off_nxt;
  logic                                res_fr_r, res_fr_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic [pba_pkg::OUT_TDATA_W-1:0]     out_data_r, out_data_nxt;
  logic [pba_pkg::OUT_TUSER_W-1:0]     out_user_r, out_user_nxt;

  pba_pkg::alu_op_t                    alu_op;
  pba_pkg::alu_res_t                   alu_rslt;
  pba_pkg::pt_cmd_t                    pt_cmd;
  logic [pba_pkg::SIZE_W-1:0]          cap_rd;
  logic [pba_pkg::SIZE_W-1:0]          fill_rd;

  logic [pba_pkg::OFF_W-1:0]           align_mask;
  logic                                cfg_wr;
  logic                                out_free;
  logic [pba_pkg::CNT_W-1:0]           next_page;

  pba_alu u_alu (
    .op   (alu_op),
    .rslt (alu_rslt)
  );

  pba_page_table u_page_table (
    .clk     (clk),
    .cmd     (pt_cmd),
    .rd_addr (active_r),
    .cap_rd  (cap_rd),
    .fill_rd (fill_rd)
  );

  // Alignment minus one, as a mask of the low align_log2 bits.
  assign align_mask = ~({pba_pkg::OFF_W{1'b1}} << alog_r);
  assign next_page  = pba_pkg::CNT_W'(active_r) + pba_pkg::CNT_W'(1);
  assign out_free   = !out_valid_r || out_tready;

  // Configuration: one register, decoded from address bit 2.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == pba_pkg::REG_DEFAULT_PAGE) ? default_r : '0;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    state_nxt      = state_r;
    req_type_nxt   = req_type_r;
    size_nxt       = size_r;
    alog_nxt       = alog_r;
    frame_nxt      = frame_r;
    default_nxt    = default_r;
    total_nxt      = total_r;
    active_nxt     = active_r;
    prev_nxt       = prev_r;
    granted_nxt    = granted_r;
    pass_nxt       = pass_r;
    off_nxt        = off_r;
    need_nxt       = need_r;
    need_gt_nxt    = need_gt_r;
    res_status_nxt = res_status_r;
    res_page_nxt   = res_page_r;
    res_off_nxt    = res_off_r;
    res_fr_nxt     = res_fr_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    out_valid_nxt  = out_valid_r && !out_tready;

    alu_op         = '0;
    pt_cmd         = '0;

    if (cfg_wr && (cfg_paddr[2] == pba_pkg::REG_DEFAULT_PAGE)) begin
      default_nxt = cfg_pwdata;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          req_type_nxt = in_tuser;
          size_nxt     = in_tdata[31:0];
          alog_nxt     = in_tdata[36:32];
          frame_nxt    = in_tdata[100:37];
          state_nxt    = S_START;
        end
      end

      S_START: begin
        res_off_nxt = '0;
        res_fr_nxt  = 1'b0;
        if (req_type_r == pba_pkg::REQ_FRAME) begin
          res_status_nxt = pba_pkg::ST_OK;
          res_page_nxt   = active_r;
          if (frame_r != prev_r) begin
            // A new frame number drops every allocation of the old frame.
            prev_nxt        = frame_r;
            active_nxt      = '0;
            granted_nxt     = '0;
            pt_cmd.clr_fill = 1'b1;
            res_page_nxt    = '0;
            res_fr_nxt      = 1'b1;
          end
          state_nxt = S_EMIT;
        end else if (size_r == '0) begin
          res_status_nxt = pba_pkg::ST_NULL;
          res_page_nxt   = active_r;
          state_nxt      = S_EMIT;
        end else begin
          pass_nxt = 1'b0;
          if (total_r == '0) begin
            // The first real allocation creates page 0 at the default size.
            pt_cmd.wr_cap  = 1'b1;
            pt_cmd.wr_fill = 1'b1;
            pt_cmd.wr_addr = '0;
            pt_cmd.cap     = default_r;
            pt_cmd.fill    = '0;
            total_nxt      = pba_pkg::CNT_W'(1);
            active_nxt     = '0;
          end
          state_nxt = S_ROUND;
        end
      end

      S_ROUND: begin
        alu_op.a       = pba_pkg::ALU_W'(fill_rd);
        alu_op.b       = pba_pkg::ALU_W'(align_mask);
        alu_op.mask    = align_mask;
        alu_op.mask_en = 1'b1;
        off_nxt        = alu_rslt.res[pba_pkg::OFF_W-1:0];
        state_nxt      = S_CHECK;
      end

      S_CHECK: begin
        alu_op.a = pba_pkg::ALU_W'(off_r);
        alu_op.b = pba_pkg::ALU_W'(size_r);
        alu_op.c = pba_pkg::ALU_W'(cap_rd);
        if (!alu_rslt.gt) begin
          pt_cmd.wr_fill = 1'b1;
          pt_cmd.wr_addr = active_r;
          pt_cmd.fill    = alu_rslt.sum[pba_pkg::SIZE_W-1:0];
          state_nxt      = S_ACCUM;
        end else if (pass_r) begin
          // Even the fresh page cannot hold the block.
          res_status_nxt = pba_pkg::ST_TOO_LARGE;
          res_page_nxt   = active_r;
          res_off_nxt    = '0;
          res_fr_nxt     = 1'b0;
          state_nxt      = S_EMIT;
        end else if (next_page < total_r) begin
          // Move on to an existing page and start it empty.
          active_nxt     = next_page[pba_pkg::PAGE_W-1:0];
          pt_cmd.wr_fill = 1'b1;
          pt_cmd.wr_addr = next_page[pba_pkg::PAGE_W-1:0];
          pt_cmd.fill    = '0;
          pass_nxt       = 1'b1;
          state_nxt      = S_ROUND;
        end else begin
          state_nxt = S_NEED;
        end
      end

      S_NEED: begin
        // Aligned request size, compared with the default page size.
        alu_op.a       = pba_pkg::ALU_W'(size_r);
        alu_op.b       = pba_pkg::ALU_W'(align_mask);
        alu_op.mask    = align_mask;
        alu_op.mask_en = 1'b1;
        alu_op.c       = pba_pkg::ALU_W'(default_r);
        need_nxt       = alu_rslt.res[pba_pkg::OFF_W-1:0];
        need_gt_nxt    = alu_rslt.gt;
        state_nxt      = S_APPEND;
      end

      S_APPEND: begin
        if (total_r == pba_pkg::CNT_W'(pba_pkg::MAX_PAGES)) begin
          res_status_nxt = pba_pkg::ST_NO_PAGE;
          res_page_nxt   = active_r;
          res_off_nxt    = '0;
          res_fr_nxt     = 1'b0;
          state_nxt      = S_EMIT;
        end else begin
          pt_cmd.wr_cap  = 1'b1;
          pt_cmd.wr_fill = 1'b1;
          pt_cmd.wr_addr = total_r[pba_pkg::PAGE_W-1:0];
          pt_cmd.fill    = '0;
          if (!need_gt_r) begin
            pt_cmd.cap = default_r;
          end else if (need_r[pba_pkg::OFF_W-1]) begin
            // Capacity above the 32-bit range saturates.
            pt_cmd.cap = '1;
          end else begin
            pt_cmd.cap = need_r[pba_pkg::SIZE_W-1:0];
          end
          active_nxt = total_r[pba_pkg::PAGE_W-1:0];
          total_nxt  = total_r + pba_pkg::CNT_W'(1);
          pass_nxt   = 1'b1;
          state_nxt  = S_ROUND;
        end
      end

      S_ACCUM: begin
        alu_op.a = pba_pkg::ALU_W'(granted_r);
        alu_op.b = pba_pkg::ALU_W'(size_r);
        if (alu_rslt.sum[pba_pkg::ALU_W-1]) begin
          granted_nxt = '1;
        end else begin
          granted_nxt = alu_rslt.sum[pba_pkg::USED_W-1:0];
        end
        res_status_nxt = pba_pkg::ST_OK;
        res_page_nxt   = active_r;
        res_off_nxt    = off_r[pba_pkg::SIZE_W-1:0];
        res_fr_nxt     = 1'b0;
        state_nxt      = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, granted_r, res_off_r,
                           pba_pkg::PAGE_IDX_W'(res_page_r)};
          out_user_nxt  = {res_fr_r, res_status_r};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      default_r   <= pba_pkg::DEFAULT_PAGE_RESET;
      total_r     <= '0;
      active_r    <= '0;
      prev_r      <= '0;
      granted_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      default_r   <= default_nxt;
      total_r     <= total_nxt;
      active_r    <= active_nxt;
      prev_r      <= prev_nxt;
      granted_r   <= granted_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_type_r   <= req_type_nxt;
    size_r       <= size_nxt;
    alog_r       <= alog_nxt;
    frame_r      <= frame_nxt;
    pass_r       <= pass_nxt;
    off_r        <= off_nxt;
    need_r       <= need_nxt;
    need_gt_r    <= need_gt_nxt;
    res_status_r <= res_status_nxt;
    res_page_r   <= res_page_nxt;
    res_off_r    <= res_off_nxt;
    res_fr_r     <= res_fr_nxt;
    out_data_r   <= out_data_nxt;
    out_user_r   <= out_user_nxt;
  end

endmodule

[rtl/core/pba_alu.sv]
// Shared add, align-up and compare unit of the paged bump allocator.
// Depends on pba_pkg for widths and the operand and result structs.
module pba_alu (
  input  pba_pkg::alu_op_t  op,
  output pba_pkg::alu_res_t rslt
);

  logic [pba_pkg::ALU_W-1:0] sum;
  logic [pba_pkg::ALU_W-1:0] wide_mask;
  logic [pba_pkg::ALU_W-1:0] res;

  assign sum       = op.a + op.b;
  assign wide_mask = pba_pkg::ALU_W'(op.mask);
  // With the mask applied, a + mask then clearing the mask bits rounds a up.
  assign res       = op.mask_en ? (sum & ~wide_mask) : sum;

  assign rslt.sum = sum;
  assign rslt.res = res;
  assign rslt.gt  = (res > op.c);

endmodule

[rtl/core/pba_page_table.sv]
// Page capacity and fill registers of the paged bump allocator, one read port.
// Depends on pba_pkg for widths and the write command struct.
module pba_page_table (
  input  logic                          clk,
  input  pba_pkg::pt_cmd_t              cmd,
  input  logic [pba_pkg::PAGE_W-1:0]    rd_addr,
  output logic [pba_pkg::SIZE_W-1:0]    cap_rd,
  output logic [pba_pkg::SIZE_W-1:0]    fill_rd
);

  logic [pba_pkg::SIZE_W-1:0] cap_r  [pba_pkg::MAX_PAGES];
  logic [pba_pkg::SIZE_W-1:0] fill_r [pba_pkg::MAX_PAGES];

  always_ff @(posedge clk) begin
    if (cmd.wr_cap) begin
      cap_r[cmd.wr_addr] <= cmd.cap;
    end
    if (cmd.clr_fill) begin
      for (int i = 0; i < pba_pkg::MAX_PAGES; i++) begin
        fill_r[i] <= '0;
      end
    end else if (cmd.wr_fill) begin
      fill_r[cmd.wr_addr] <= cmd.fill;
    end
  end

  assign cap_rd  = cap_r[rd_addr];
  assign fill_rd = fill_r[rd_addr];

endmodule

[rtl/core/pba_checker.sv]
// Port-level checker for the paged bump allocator, bound to the top level.
// Depends on pba_pkg and paged_bump_allocator_macros.svh.
`include "paged_bump_allocator_macros.svh"

module pba_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [pba_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input logic [pba_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  // A stalled result keeps its transaction intact.
  `PBA_ASSERT_NEXT(a_out_hold, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // One request at a time: acceptance closes the input until the result is built.
  `PBA_ASSERT_NEXT(a_one_at_a_time, rst_n, in_tvalid && in_tready, !in_tready)

  // A frame reset reports page 0, no bytes in use and an ok status.
  `PBA_ASSERT_SAME(a_frame_reset, rst_n, out_tvalid && out_tuser[2], (out_tuser[1:0] == pba_pkg::ST_OK) && (out_tdata[2:0] == '0) && (out_tdata[70:35] == '0))

  // Any failed or null request carries a zero offset.
  `PBA_ASSERT_SAME(a_fail_offset, rst_n, out_tvalid && (out_tuser[1:0] != pba_pkg::ST_OK), out_tdata[34:3] == '0)

endmodule

bind paged_bump_allocator pba_checker u_pba_checker (.*);

[tb/paged_bump_allocator_checker.sv]
`timescale 1ns / 100ps
// Result checker for the paged bump allocator: watches the request, result and APB ports,
// predicts each result from its own copy of the page table and compares them in order.
// Depends on pba_pkg.
module paged_bump_allocator_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [pba_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [pba_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [pba_pkg::OUT_TUSER_W-1:0] out_tuser,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [pba_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [pba_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  input  logic [pba_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  input  logic                            cfg_pready,
  output int                              mismatches,
  output int                              pending
);
  import pba_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] DEFAULT_PAGE_ADDR = {REG_DEFAULT_PAGE, 2'b00};

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [PAGE_IDX_W-1:0] page;
    logic [SIZE_W-1:0]     offset;
    logic [USED_W-1:0]     used;
    logic                  frame_reset;
  } alloc_outcome_t;

  alloc_outcome_t        awaited[$];
  logic [SIZE_W-1:0]     page_cap  [MAX_PAGES];
  logic [SIZE_W-1:0]     page_fill [MAX_PAGES];
  int                    pages_made;
  logic [PAGE_IDX_W-1:0] cur_page;
  logic [FRAME_W-1:0]    last_frame;
  logic [USED_W-1:0]     granted;
  logic [SIZE_W-1:0]     std_page_bytes;

  function automatic logic [32:0] align_up(input logic [32:0] v, input logic [4:0] lg);
    logic [32:0] m;
    m = (33'd1 << lg) - 33'd1;
    return (v + m) & ~m;
  endfunction

  function automatic logic fits(input logic [32:0] off, input logic [31:0] bytes,
                                input logic [31:0] cap);
    return ({1'b0, off} + 34'(bytes)) <= 34'(cap);
  endfunction

  function automatic string describe(input alloc_outcome_t o);
    return $sformatf("status %0d page %0d offset 0x%08h used 0x%09h frame_reset %0b",
                     o.status, o.page, o.offset, o.used, o.frame_reset);
  endfunction

  // Applies one request to the shadow page table and returns the result it must produce.
  function automatic alloc_outcome_t next_outcome(input logic kind, input logic [31:0] bytes,
                                                  input logic [4:0] lg,
                                                  input logic [63:0] frame);
    alloc_outcome_t r;
    logic [32:0]    off;
    logic [32:0]    need;
    logic [36:0]    sum;
    r = '{status: ST_OK, page: '0, offset: '0, used: '0, frame_reset: 1'b0};
    if (kind == REQ_FRAME) begin
      if (frame != last_frame) begin
        last_frame = frame;
        for (int i = 0; i < MAX_PAGES; i++) page_fill[i] = '0;
        cur_page = '0;
        granted = '0;
        r.frame_reset = 1'b1;
      end
      r.page = cur_page;
      r.used = granted;
      return r;
    end
    if (bytes == '0) begin
      r.status = ST_NULL;
      r.page = cur_page;
      r.used = granted;
      return r;
    end
    // The first real allocation creates page 0 at the standard size.
    if (pages_made == 0) begin
      page_cap[0] = std_page_bytes;
      page_fill[0] = '0;
      pages_made = 1;
      cur_page = '0;
    end
    off = align_up({1'b0, page_fill[cur_page]}, lg);
    if (!fits(off, bytes, page_cap[cur_page])) begin
      if (int'(cur_page) + 1 < pages_made) begin
        cur_page = cur_page + 1'b1;
        page_fill[cur_page] = '0;
      end else if (pages_made >= MAX_PAGES) begin
        r.status = ST_NO_PAGE;
        r.page = cur_page;
        r.used = granted;
        return r;
      end else begin
        need = align_up({1'b0, bytes}, lg);
        if (need > {1'b0, std_page_bytes})
          page_cap[pages_made] = need[32] ? '1 : need[31:0];
        else
          page_cap[pages_made] = std_page_bytes;
        page_fill[pages_made] = '0;
        cur_page = PAGE_IDX_W'(pages_made);
        pages_made++;
      end
      off = align_up({1'b0, page_fill[cur_page]}, lg);
      if (!fits(off, bytes, page_cap[cur_page])) begin
        r.status = ST_TOO_LARGE;
        r.page = cur_page;
        r.used = granted;
        return r;
      end
    end
    page_fill[cur_page] = off[31:0] + bytes;
    sum = {1'b0, granted} + 37'(bytes);
    granted = sum[36] ? '1 : sum[35:0];
    r.page = cur_page;
    r.offset = off[31:0];
    r.used = granted;
    return r;
  endfunction

  task automatic tally(input string msg);
    if (mismatches < 10) $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    alloc_outcome_t got;
    alloc_outcome_t want;
    if (!rst_n) begin
      pages_made = 0;
      cur_page = '0;
      last_frame = '0;
      granted = '0;
      std_page_bytes = DEFAULT_PAGE_RESET;
      awaited.delete();
      mismatches = 0;
      pending <= 0;
    end else begin
      // Results are checked before requests are taken in, since a request never
      // produces its result at the edge where it is accepted.
      if (out_tvalid && out_tready) begin
        got = '{status: out_tuser[1:0], page: out_tdata[2:0], offset: out_tdata[34:3],
                used: out_tdata[70:35], frame_reset: out_tuser[2]};
        if (awaited.size() == 0) begin
          tally({"result with none awaited: ", describe(got)});
        end else begin
          want = awaited.pop_front();
          if (got !== want)
            tally({"result mismatch, expected ", describe(want), ", got ", describe(got)});
        end
      end
      if (in_tvalid && in_tready)
        awaited.push_back(next_outcome(in_tuser, in_tdata[31:0], in_tdata[36:32],
                                       in_tdata[100:37]));
      if (cfg_psel && cfg_penable && cfg_pready && cfg_paddr == DEFAULT_PAGE_ADDR) begin
        if (cfg_pwrite)
          std_page_bytes = cfg_pwdata;
        else if (cfg_prdata !== std_page_bytes)
          tally($sformatf("default_page_bytes read mismatch, expected 0x%08h, got 0x%08h",
                          std_page_bytes, cfg_prdata));
      end
      pending <= awaited.size();
    end
  end

endmodule

[tb/paged_bump_allocator_tb.sv]
`timescale 1ns / 100ps
// Top of the paged bump allocator testbench: clock, reset, request and APB stimulus,
// random result back-pressure and the final verdict.
// Depends on pba_pkg, paged_bump_allocator and paged_bump_allocator_checker.
module paged_bump_allocator_tb;
  import pba_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] DEFAULT_PAGE_ADDR = {REG_DEFAULT_PAGE, 2'b00};
  localparam int RANDOM_REQUESTS = 1150;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = REQ_ALLOC;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  int          mismatches;
  int          pending;
  int unsigned issued = 0;
  // When low, the request side sends back to back for a whole phase.
  logic        sender_idles = 1'b1;
  logic [63:0] frame_ctr;

  initial forever #6 clk = ~clk;

  paged_bump_allocator uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  paged_bump_allocator_checker grant_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .pending     (pending)
  );

  // Idle lengths: mostly none or a few cycles, now and then a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Presents one request and holds it until the block accepts it. With no gap
  // the valid simply stays high for the next request.
  task automatic issue(input logic kind, input logic [31:0] bytes, input logic [4:0] lg,
                       input logic [63:0] frame);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{(IN_TDATA_W - 101){1'b0}}, frame, lg, bytes};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    issued++;
    gap = sender_idles ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every awaited result has been taken. The checker
  // registers its count, so the task waits for the next clock edge before looking.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One APB transfer to default_page_bytes: setup cycle, then access until pready.
  task automatic cfg_access(input logic wr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= DEFAULT_PAGE_ADDR;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // The register is only written with the block idle; a read back follows each write.
  task automatic set_default_page(input logic [31:0] value);
    drain();
    cfg_access(1'b1, value);
    cfg_access(1'b0, '0);
  endtask

  // Result side back-pressure: bursts of ready broken by stalls, plus long stretches
  // with no stall at all.
  initial begin : result_sink
    int unsigned stall;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(50, 300)) @(posedge clk);
      else
        repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int unsigned r;
    int unsigned target;
    int          phase;
    logic [31:0] bytes;
    logic [4:0]  lg;
    logic [31:0] cfg_val;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The register must read its reset value first.
    cfg_access(1'b0, '0);
    // Zero size before any page exists: null status, no page is created.
    issue(REQ_ALLOC, 32'd0, 5'd31, {$urandom, $urandom});
    // New frame carrying the reset frame number changes nothing.
    issue(REQ_FRAME, $urandom, 5'($urandom), 64'd0);
    // New frame with every frame bit set clears allocation.
    issue(REQ_FRAME, $urandom, 5'($urandom), '1);
    // Zero default size: page 0 gets capacity zero, so the allocator appends page 1
    // sized by the request itself.
    set_default_page(32'd0);
    issue(REQ_ALLOC, 32'd1, 5'd0, {$urandom, $urandom});
    // Appended pages sized by the request, then by the default.
    set_default_page(32'd256);
    issue(REQ_ALLOC, 32'd300, 5'd2, {$urandom, $urandom});
    issue(REQ_ALLOC, 32'd10, 5'd8, {$urandom, $urandom});
    issue(REQ_ALLOC, 32'd100, 5'd5, {$urandom, $urandom});
    set_default_page(32'd1);
    issue(REQ_ALLOC, 32'd200, 5'd0, {$urandom, $urandom});
    set_default_page(32'd1024);
    issue(REQ_ALLOC, 32'd1, 5'd0, {$urandom, $urandom});
    issue(REQ_ALLOC, 32'd2000, 5'd3, {$urandom, $urandom});
    // Largest default, and an aligned size past 32 bits: the last page saturates.
    set_default_page('1);
    issue(REQ_ALLOC, 32'h8000_0001, 5'd31, {$urandom, $urandom});
    // Page table full: one byte too many, then an exact fit, then full again.
    issue(REQ_ALLOC, 32'h7FFF_FFFF, 5'd0, {$urandom, $urandom});
    issue(REQ_ALLOC, 32'h7FFF_FFFE, 5'd0, {$urandom, $urandom});
    issue(REQ_ALLOC, 32'd1, 5'd0, {$urandom, $urandom});
    issue(REQ_FRAME, $urandom, 5'($urandom), 64'd1);
    // Next page too small: the move stays in effect and the request fails.
    issue(REQ_ALLOC, '1, 5'd0, {$urandom, $urandom});
    issue(REQ_ALLOC, 32'd1, 5'd0, {$urandom, $urandom});
    // Largest alignment pushes the offset past the page and moves on.
    issue(REQ_ALLOC, 32'd4, 5'd31, {$urandom, $urandom});
    // Same frame number again while on a later page.
    issue(REQ_FRAME, $urandom, 5'($urandom), 64'd1);
    issue(REQ_ALLOC, 32'd0, 5'd0, {$urandom, $urandom});
    issue(REQ_ALLOC, '1, 5'd16, {$urandom, $urandom});
    frame_ctr = 64'h8000_0000_0000_0000;
    issue(REQ_FRAME, $urandom, 5'($urandom), frame_ctr);

    // Random part: frames of allocations with random content. Each phase starts
    // idle with a new default page size; the page table fills early and is then
    // walked frame after frame.
    target = issued + RANDOM_REQUESTS;
    phase = 0;
    while (issued < target) begin
      case (phase % 6)
        0: cfg_val = 32'd0;
        1: cfg_val = 32'd1;
        2: cfg_val = '1;
        3: cfg_val = $urandom_range(64, 4096);
        4: cfg_val = $urandom;
        default: cfg_val = DEFAULT_PAGE_RESET;
      endcase
      set_default_page(cfg_val);
      sender_idles = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(3, 8)) begin
        if (issued >= target) break;
        // Mostly a fresh frame number; sometimes the same one, sometimes a jump.
        r = $urandom_range(0, 99);
        if (r >= 10)
          frame_ctr = (r < 95) ? frame_ctr + $urandom_range(1, 3) : {$urandom, $urandom};
        issue(REQ_FRAME, $urandom, 5'($urandom), frame_ctr);
        repeat ($urandom_range(2, 40)) begin
          if (issued >= target) break;
          r = $urandom_range(0, 99);
          if (r < 4)       bytes = '0;
          else if (r < 70) bytes = $urandom_range(1, 128);
          else if (r < 88) bytes = $urandom_range(129, 2048);
          else if (r < 95) bytes = $urandom_range(2049, 65536);
          else if (r < 98) bytes = $urandom | 32'h8000_0000;
          else             bytes = $urandom;
          r = $urandom_range(0, 99);
          if (r < 80)      lg = 5'($urandom_range(0, 4));
          else if (r < 95) lg = 5'($urandom_range(5, 12));
          else             lg = 5'($urandom_range(13, 31));
          // Occasionally hold off until the block has returned everything.
          if ($urandom_range(0, 49) == 0) drain();
          issue(REQ_ALLOC, bytes, lg, {$urandom, $urandom});
        end
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/pba_pkg.sv
rtl/core/pba_alu.sv
rtl/core/pba_page_table.sv
rtl/core/paged_bump_allocator.sv
rtl/core/pba_checker.sv
tb/paged_bump_allocator_checker.sv
tb/paged_bump_allocator_tb.sv
